FILE: design/sdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_pkg: shared definitions for the sorted date table.
// Field widths, operation and status codes, and the date check helpers.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // Default sizing of the table.
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned MIN_YEAR_DEF = 1900;

  // Field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned KEY_W    = DAY_W + MONTH_W + YEAR_W;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = OP_W;
  localparam int unsigned OUT_DATA_W = ((2 * POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = STATUS_W;

  // Divisibility by 25 of a 16-bit year: multiply by the inverse of 25
  // modulo 2^16; the low half is small exactly when the year is a multiple.
  localparam logic [YEAR_W-1:0] INV25       = 16'h5C29;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

  localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISS    = 2'd3
  } status_t;

  // Length of a month in a common year; codes that are no month give zero.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: design/sdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module sdt_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/sorted_date_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_date_table_unit: ordered table of calendar dates.
// Appends, inserts in order, searches and removes dates held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_tvalid/s_tready with the operation in
//   s_tuser and the date in s_tdata. Each input transaction yields exactly
//   one output transaction on m_tvalid/m_tready carrying the status in
//   m_tuser and the position and entry count in m_tdata.
//   Every date is checked first (Gregorian leap rule, year above MIN_YEAR);
//   an invalid date leaves the table untouched.
//   One item is processed at a time. Append goes straight from the date
//   check to the write. Search scans one entry per cycle through the
//   single RAM read port. Ordered insert and remove scan the table and
//   then move the later entries one place per cycle through the same port.
//   The result sits in an output register, so s_tready returns as soon as
//   the result is loaded, even while the receiver stalls; a second result
//   waits in the engine until the first has been taken.
//   Reset empties the table at once (the entry count is cleared); the RAM
//   needs no clearing pass since only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_date_table_unit #(
  parameter int unsigned DEPTH    = sdt_pkg::DEPTH_DEF,
  parameter int unsigned MIN_YEAR = sdt_pkg::MIN_YEAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // day [4:0], month [8:5], year [24:9], zero padding above.
  input  logic [sdt_pkg::IN_DATA_W-1:0]  s_tdata,
  // op [1:0].
  input  logic [sdt_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // position [4:0], entry_count [9:5], zero padding above.
  output logic [sdt_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [1:0].
  output logic [sdt_pkg::OUT_USER_W-1:0] m_tuser
);

  import sdt_pkg::*;

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [YEAR_W-1:0] MIN_YEAR_V = YEAR_W'(MIN_YEAR);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  op_t               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [YEAR_W-1:0] prod_q;
  status_t           status_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  issue_idx;
  logic              pend;
  logic [CNT_W-1:0]  pend_idx;
  logic              lt_head;
  logic              le_prev;
  logic              found;
  logic [CNT_W-1:0]  cand;
  logic [CNT_W-1:0]  src;
  logic [CNT_W-1:0]  rem;
  logic              sh_up;
  logic [ADDR_W-1:0] sh_dst;

  logic [2*YEAR_W-1:0] prod_full;
  logic [DAY_W-1:0]    day_q;
  logic [MONTH_W-1:0]  month_q;
  logic [YEAR_W-1:0]   year_q;
  logic                leap;
  logic [DAY_W-1:0]    mlen;
  logic                date_ok;
  logic                full;

  logic [KEY_W-1:0]  rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;

  logic             eq, le, lt, gt;
  logic             is_head, is_last, head_lt, hit_now, found_now;
  logic [CNT_W-1:0] cand_now;
  logic [CNT_W-1:0] ins_pos;

  // Date check: the year is multiplied on acceptance, then tested here.
  assign prod_full = (2*YEAR_W)'(s_tdata[KEY_W-1:DAY_W+MONTH_W]) * (2*YEAR_W)'(INV25);
  assign day_q   = key_q[DAY_W-1:0];
  assign month_q = key_q[DAY_W+MONTH_W-1:DAY_W];
  assign year_q  = key_q[KEY_W-1:DAY_W+MONTH_W];

  always_comb begin
    leap = (year_q[1:0] == 2'd0) && ((prod_q > DIV25_LIMIT) || (year_q[3:0] == 4'd0));
    mlen = month_len(month_q);
    if ((month_q == MONTH_FEB) && leap) begin
      mlen = FEB_LEAP_LEN;
    end
    date_ok = (month_q != '0) && (month_q <= MONTH_DEC) && (year_q > MIN_YEAR_V) &&
              (day_q != '0) && (day_q <= mlen);
  end

  assign full = (count == CNT_FULL);

  // Comparison of the entry just read against the item's date.
  always_comb begin
    eq        = (key_q == rd_data);
    le        = (key_q <= rd_data);
    lt        = (key_q < rd_data);
    gt        = (key_q > rd_data);
    is_head   = (pend_idx == '0);
    is_last   = pend && (pend_idx == count - CNT_ONE);
    head_lt   = is_head ? lt : lt_head;
    hit_now   = !is_head && (le_prev || le);
    found_now = found || hit_now;
    cand_now  = found ? cand : pend_idx;
    if (head_lt) begin
      ins_pos = '0;
    end else if (gt || !found_now) begin
      ins_pos = count;
    end else begin
      ins_pos = cand_now;
    end
  end

  // RAM port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    case (state)
      S_SCAN: begin
        rd_en   = (issue_idx < count);
        rd_addr = issue_idx[ADDR_W-1:0];
      end
      S_SHIFT: begin
        rd_en   = (rem != '0);
        rd_addr = src[ADDR_W-1:0];
        wr_en   = pend;
        wr_addr = sh_dst;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[ADDR_W-1:0];
        wr_data = key_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  sdt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);

  // Control sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // The output register empties on a handshake unless a new result
      // is loaded in the same cycle.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= op_t'(s_tuser[OP_W-1:0]);
            key_q    <= s_tdata[KEY_W-1:0];
            prod_q   <= prod_full[YEAR_W-1:0];
            pos_q    <= '0;
            status_q <= STAT_OK;
            state    <= S_CHECK;
          end
        end

        S_CHECK: begin
          issue_idx <= '0;
          pend      <= 1'b0;
          found     <= 1'b0;
          if (!date_ok) begin
            status_q <= STAT_INVALID;
            state    <= S_DONE;
          end else if ((op_q == OP_APPEND) || (op_q == OP_INSERT)) begin
            if (full) begin
              status_q <= STAT_FULL;
              state    <= S_DONE;
            end else if ((op_q == OP_APPEND) || (count == '0)) begin
              pos_q <= count;
              state <= S_PUT;
            end else begin
              state <= S_SCAN;
            end
          end else if (count == '0) begin
            status_q <= STAT_MISS;
            state    <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end

        // One entry is read per cycle; its data is compared in the next cycle.
        S_SCAN: begin
          if (issue_idx < count) begin
            issue_idx <= issue_idx + CNT_ONE;
          end
          // The pipeline is flushed when the scan ends on this entry.
          if (pend && ((op_q == OP_INSERT) ? is_last : eq)) begin
            pend <= 1'b0;
          end else begin
            pend <= (issue_idx < count);
          end
          pend_idx <= issue_idx;
          if (pend) begin
            if (op_q == OP_INSERT) begin
              if (is_head) begin
                lt_head <= lt;
              end
              le_prev <= le;
              found   <= found_now;
              cand    <= cand_now;
              if (is_last) begin
                pos_q <= ins_pos;
                rem   <= count - ins_pos;
                src   <= count - CNT_ONE;
                sh_up <= 1'b1;
                state <= S_SHIFT;
              end
            end else if (eq) begin
              pos_q <= pend_idx;
              if (op_q == OP_REMOVE) begin
                rem   <= count - CNT_ONE - pend_idx;
                src   <= pend_idx + CNT_ONE;
                sh_up <= 1'b0;
                state <= S_SHIFT;
              end else begin
                state <= S_DONE;
              end
            end else if (is_last) begin
              status_q <= STAT_MISS;
              state    <= S_DONE;
            end
          end
        end

        // Move entries one place: read a source now, write it in the next cycle.
        S_SHIFT: begin
          if (rem != '0) begin
            pend   <= 1'b1;
            sh_dst <= sh_up ? ADDR_W'(src + CNT_ONE) : ADDR_W'(src - CNT_ONE);
            src    <= sh_up ? (src - CNT_ONE) : (src + CNT_ONE);
            rem    <= rem - CNT_ONE;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (op_q == OP_REMOVE) begin
                count <= count - CNT_ONE;
                state <= S_DONE;
              end else begin
                state <= S_PUT;
              end
            end
          end
        end

        S_PUT: begin
          count <= count + CNT_ONE;
          state <= S_DONE;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= OUT_USER_W'(status_q);
            m_tdata  <= OUT_DATA_W'({POS_W'(count), POS_W'(pos_q)});
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count above table depth");

  // Scanning never writes the store.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("store written during scan");

  // A full status is only reported when the table really is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (status_q == STAT_FULL)) |-> full)
    else $error("full status with free entries");

  // A failed item reports position zero.
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata[POS_W-1:0] == '0))
    else $error("non-zero position on failure");
`endif

endmodule
